@@ rtl/sprb_pkg.sv @@
// Shared types and codes for the shifted sprite row blitter.
// No dependencies; imported by sprb_align and shifted_sprite_row_blit.
package sprb_pkg;

    typedef enum logic [1:0] {
        MODE_OR      = 2'd0,
        MODE_XOR     = 2'd1,
        MODE_REPLACE = 2'd2,
        MODE_READ    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_FIN
    } state_t;

    // Row pixels shifted onto three adjacent frame words, leftmost word at index 0
    typedef logic [2:0][31:0] parts_t;

endpackage

@@ rtl/sprb_align.sv @@
// Sprite row alignment: masks the row to its width, left-aligns it and shifts it
// across three frame words. Depends on sprb_pkg.
module sprb_align
    import sprb_pkg::*;
(
    input  logic [63:0] row_data,
    input  logic [1:0]  width_code,
    input  logic [4:0]  shift,
    output parts_t      parts,
    output logic [1:0]  last_word
);

    logic [63:0] left;
    logic [95:0] spread;
    logic [6:0]  wbits;
    logic [6:0]  end_col;

    always_comb begin
        unique case (width_code)
            2'd0:    left = {row_data[7:0], 56'd0};
            2'd1:    left = {row_data[15:0], 48'd0};
            2'd2:    left = {row_data[31:0], 32'd0};
            default: left = row_data;
        endcase
    end

    // Shift by zero leaves the third word empty
    assign spread = {left, 32'd0} >> shift;
    assign parts[0] = spread[95:64];
    assign parts[1] = spread[63:32];
    assign parts[2] = spread[31:0];

    assign wbits     = 7'd8 << width_code;
    assign end_col   = 7'(shift) + wbits - 7'd1;
    assign last_word = end_col[6:5];

endmodule

@@ rtl/shifted_sprite_row_blit.sv @@
// Shifted sprite row blitter: top level with frame store, sequencer and output register.
// Depends on sprb_pkg and sprb_align.
//
// A one-bit-per-pixel frame store of LINE_COUNT lines of (LINE_PIXELS+31)/32 words,
// MSB leftmost. After reset the block clears the store one word per cycle and takes no
// word until that is done. Each word then blits one sprite row (OR, XOR or replace) or
// reads one frame word, and returns one result word. The store has one read and one
// write port, so a blit covering n words (1 to 3) reads its first word ahead, then does
// one read-modify-write per word, reading the next word while writing this one, then
// posts the result. A read takes the same steps for one word without a write; a rejected
// item or a row below the last line goes straight to posting. No new item is taken until then.
// A finished result waits in the output register while the next word is worked on.
module shifted_sprite_row_blit
    import sprb_pkg::*;
#(
    parameter int LINE_PIXELS = 640,
    parameter int LINE_COUNT  = 400
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[1:0], x[12:2], y[23:13], row_index[29:24], width_code[31:30], row_data[95:32]
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_word[31:0], rejected[32], zero[39:33]
    output logic [39:0] m_tdata
);

    localparam int WPL         = (LINE_PIXELS + 31) / 32;
    localparam int STORE_WORDS = WPL * LINE_COUNT;
    localparam int AW          = $clog2(STORE_WORDS);
    localparam int TAIL        = LINE_PIXELS % 32;
    localparam logic [31:0] LAST_MASK = (TAIL == 0) ? 32'hFFFF_FFFF
                                                    : ~(32'hFFFF_FFFF >> TAIL);

    // input field decode
    logic [1:0]  in_mode;
    logic [10:0] in_x;
    logic [10:0] in_y;
    logic [5:0]  in_row;
    logic [1:0]  in_width;
    logic [63:0] in_data;

    assign in_mode  = s_tdata[1:0];
    assign in_x     = s_tdata[12:2];
    assign in_y     = s_tdata[23:13];
    assign in_row   = s_tdata[29:24];
    assign in_width = s_tdata[31:30];
    assign in_data  = s_tdata[95:32];

    logic        accept;
    logic        in_reject;
    logic        in_skip;
    logic [10:0] in_line;
    logic [10:0] in_target;
    logic [5:0]  in_wc;
    logic [5:0]  in_room;
    logic [17:0] in_row_base;
    logic [AW-1:0] in_base;
    parts_t      in_parts;
    logic [1:0]  in_last;
    logic [1:0]  in_last_k;

    assign accept    = s_tvalid && s_tready;
    assign in_reject = in_x[10] || ({2'b0, in_x[9:0]} >= 12'(LINE_PIXELS))
                    || in_y[10] || ({1'b0, in_y[9:0]} >= 11'(LINE_COUNT));
    assign in_line   = {1'b0, in_y[9:0]} + 11'(in_row);
    assign in_skip   = (mode_t'(in_mode) != MODE_READ) && (in_line >= 11'(LINE_COUNT));
    assign in_target = (mode_t'(in_mode) == MODE_READ) ? {1'b0, in_y[9:0]} : in_line;
    assign in_wc     = {1'b0, in_x[9:5]};
    assign in_row_base = 18'(in_target) * 18'(WPL);
    assign in_base   = AW'(in_row_base) + AW'(in_wc);
    assign in_room   = 6'(WPL - 1) - in_wc;

    sprb_align u_align (
        .row_data   (in_data),
        .width_code (in_width),
        .shift      (in_x[4:0]),
        .parts      (in_parts),
        .last_word  (in_last)
    );

    // stop at the last word of the line
    assign in_last_k = (mode_t'(in_mode) == MODE_READ) ? 2'd0
                     : ((in_room < 6'(in_last)) ? in_room[1:0] : in_last);

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_addr_reg;
    mode_t         mode_reg;
    logic [AW-1:0] base_reg;
    logic [5:0]    wc_reg;
    parts_t        parts_reg;
    logic [1:0]    last_k_reg;
    logic [1:0]    k_reg;
    logic          rej_reg;
    logic [31:0]   res_word_reg;
    logic          m_valid_reg;
    logic [31:0]   out_word_reg;
    logic          out_rej_reg;

    logic [31:0]   store [STORE_WORDS];
    logic [31:0]   mem_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic          out_free;
    logic          k_last;
    logic [1:0]    k_inc;
    logic [6:0]    word_col;
    logic [31:0]   word_mask;
    logic [31:0]   merge_bits;
    logic [31:0]   merged;

    assign out_free  = !m_valid_reg || m_tready;
    assign k_last    = (k_reg == last_k_reg);
    assign k_inc     = k_reg + 2'd1;
    assign word_col  = 7'(wc_reg) + 7'(k_reg);
    assign word_mask = (word_col == 7'(WPL - 1)) ? LAST_MASK : 32'hFFFF_FFFF;
    assign merge_bits = parts_reg[k_reg] & word_mask;

    always_comb begin
        unique case (mode_reg)
            MODE_OR:      merged = mem_rdata_reg | merge_bits;
            MODE_XOR:     merged = mem_rdata_reg ^ merge_bits;
            MODE_REPLACE: merged = (mem_rdata_reg & ~word_mask) | merge_bits;
            default:      merged = mem_rdata_reg;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == AW'(STORE_WORDS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) state_next = (in_reject || in_skip) ? ST_FIN : ST_READ;
            end
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: begin
                if (k_last) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = base_reg + AW'(k_reg);
        mem_wdata = merged;
        mem_re    = 1'b0;
        mem_raddr = base_reg + AW'(k_reg);
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = 32'd0;
            end
            ST_IDLE:  s_tready = 1'b1;
            ST_READ:  mem_re = 1'b1;
            ST_WRITE: begin
                mem_we    = (mode_reg != MODE_READ);
                // read the next word while writing this one
                mem_re    = !k_last;
                mem_raddr = base_reg + AW'(k_inc);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) store[mem_waddr] <= mem_wdata;
        if (mem_re) mem_rdata_reg <= store[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_addr_reg <= clr_addr_reg + AW'(1);
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg     <= mode_t'(in_mode);
            base_reg     <= in_base;
            wc_reg       <= in_wc;
            parts_reg    <= in_parts;
            last_k_reg   <= in_last_k;
            k_reg        <= 2'd0;
            rej_reg      <= in_reject;
            res_word_reg <= 32'd0;
        end else if (state_reg == ST_WRITE) begin
            if (mode_reg == MODE_READ) res_word_reg <= mem_rdata_reg;
            if (!k_last) k_reg <= k_inc;
        end
        if (state_reg == ST_FIN && out_free) begin
            out_word_reg <= res_word_reg;
            out_rej_reg  <= rej_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_rej_reg, out_word_reg};

endmodule
